[hdl/ccx_pkg.sv]
// ----------------------------------------------------------------------------
// Crosspoint connection table package
// Operation codes, field widths and the command and status types shared
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ccx_pkg;

  localparam int PortNumW = 4;
  localparam int MapW     = 32;
  localparam int SrcW     = 5;

  localparam logic signed [SrcW-1:0] SRC_NONE = -5'sd1;

  typedef enum logic [2:0] {
    OP_CONNECT    = 3'd0,
    OP_DISCONNECT = 3'd1,
    OP_READ       = 3'd2,
    OP_FIND       = 3'd3,
    OP_STORE      = 3'd4,
    OP_CLEAR      = 3'd5,
    OP_RESTORE    = 3'd6
  } op_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
  } ccx_cmd_t;

  typedef struct packed {
    logic restore_go;
    logic step_last;
  } ccx_status_t;

endpackage

[hdl/ccx_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ccx_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/ccx_dp.sv]
// ----------------------------------------------------------------------------
// Crosspoint connection table datapath
// Holds the two link maps, the preset store and the result register, and
// carries out one operation or one restore step per command.
// ----------------------------------------------------------------------------
module ccx_dp #(
  parameter int PORTS        = 8,
  parameter int PRESET_SLOTS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ccx_pkg::ccx_cmd_t                   cmd_i,
  output ccx_pkg::ccx_status_t                status_o,
  input  logic [2:0]                          operation_i,
  input  logic                                direction_i,
  input  logic [ccx_pkg::PortNumW-1:0]        input_port_i,
  input  logic [ccx_pkg::PortNumW-1:0]        output_port_i,
  input  logic [ccx_pkg::PortNumW-1:0]        preset_slot_i,
  input  logic [ccx_pkg::MapW-1:0]            preset_emission_map_i,
  input  logic [ccx_pkg::MapW-1:0]            preset_reception_map_i,
  input  logic                                preset_valid_i,
  output logic                                accepted_o,
  output logic [ccx_pkg::PortNumW-1:0]        connected_output_o,
  output logic signed [ccx_pkg::SrcW-1:0]     source_index_o
);

  import ccx_pkg::*;

  localparam int PORT_W = $clog2(PORTS);
  localparam int SLOT_W = (PRESET_SLOTS > 1) ? $clog2(PRESET_SLOTS) : 1;

  function automatic logic port_ok(logic [PortNumW-1:0] p);
    return (p != '0) && (p <= PortNumW'(PORTS));
  endfunction

  logic [2:0]          op_q;
  logic                dir_q;
  logic [PortNumW-1:0] inp_q;
  logic [PortNumW-1:0] outp_q;
  logic [PortNumW-1:0] slot_q;
  logic [MapW-1:0]     emap_q;
  logic [MapW-1:0]     rmap_q;
  logic                pvalid_q;

  logic [PortNumW-1:0] links_q [2][PORTS];
  logic [PortNumW-1:0] links_d [2][PORTS];
  logic [PRESET_SLOTS-1:0] flags_q;
  logic [PRESET_SLOTS-1:0] flags_d;
  logic [PORT_W-1:0]   cnt_q;
  logic [PORT_W-1:0]   cnt_d;

  logic                         acc_q;
  logic                         acc_d;
  logic [PortNumW-1:0]          conn_q;
  logic [PortNumW-1:0]          conn_d;
  logic signed [SrcW-1:0]       src_q;
  logic signed [SrcW-1:0]       src_d;

  op_e                 op;
  logic                inp_ok;
  logic                outp_ok;
  logic                slot_ok;
  logic [PORT_W-1:0]   inp_idx;
  logic [SLOT_W-1:0]   slot_idx;
  logic                flag_sel;
  logic [PortNumW-1:0] cnt4;
  logic [2*MapW-1:0]   ram_rdata;
  logic [MapW-1:0]     emap_rd;
  logic [MapW-1:0]     rmap_rd;
  logic [PortNumW-1:0] ent [2];
  logic                ram_we;

  logic [1:0]          lk_en;
  logic [1:0]          clr_en;
  logic [PORT_W-1:0]   lk_idx [2];
  logic [PortNumW-1:0] lk_out [2];
  logic [1:0]          hold_en;
  logic [PORT_W-1:0]   hold_idx [2];
  logic [PORTS-1:0]    match [2];

  assign op       = op_e'(op_q);
  assign inp_ok   = port_ok(inp_q);
  assign outp_ok  = port_ok(outp_q);
  assign slot_ok  = (slot_q != '0) && (slot_q <= PortNumW'(PRESET_SLOTS));
  assign inp_idx  = PORT_W'(inp_q - 4'd1);
  assign slot_idx = SLOT_W'(slot_q - 4'd1);
  assign flag_sel = slot_ok && flags_q[slot_idx];
  assign cnt4     = PortNumW'(cnt_q);
  assign emap_rd  = ram_rdata[MapW-1:0];
  assign rmap_rd  = ram_rdata[2*MapW-1:MapW];
  assign ent[0]   = cnt4[3] ? '0 : emap_rd[{cnt4[2:0], 2'b00} +: PortNumW];
  assign ent[1]   = cnt4[3] ? '0 : rmap_rd[{cnt4[2:0], 2'b00} +: PortNumW];
  assign ram_we   = cmd_i.exec && (op == OP_STORE) && slot_ok;

  ccx_ram #(
    .WIDTH(2 * MapW),
    .DEPTH(PRESET_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_idx),
    .wdata_i({rmap_q, emap_q}),
    .raddr_i(slot_idx),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    lk_en  = '0;
    clr_en = '0;
    for (int m = 0; m < 2; m++) begin
      lk_idx[m] = inp_idx;
      lk_out[m] = outp_q;
    end
    if (cmd_i.step) begin
      for (int m = 0; m < 2; m++) begin
        lk_idx[m] = cnt_q;
        lk_out[m] = ent[m];
        lk_en[m]  = port_ok(ent[m]);
      end
    end else if (cmd_i.exec) begin
      case (op)
        OP_CONNECT:    lk_en[dir_q]  = inp_ok && outp_ok;
        OP_DISCONNECT: clr_en[dir_q] = inp_ok;
        default:       ;
      endcase
    end
  end

  always_comb begin
    for (int m = 0; m < 2; m++) begin
      hold_idx[m] = '0;
      for (int j = 0; j < PORTS; j++) begin
        match[m][j] = (links_q[m][j] == lk_out[m]);
      end
      for (int j = PORTS - 1; j >= 0; j--) begin
        if (match[m][j]) begin
          hold_idx[m] = PORT_W'(j);
        end
      end
      hold_en[m] = |match[m];
    end
  end

  always_comb begin
    links_d = links_q;
    for (int m = 0; m < 2; m++) begin
      for (int j = 0; j < PORTS; j++) begin
        if (lk_en[m] && hold_en[m] && (hold_idx[m] == PORT_W'(j))) begin
          links_d[m][j] = '0;
        end
        if (clr_en[m] && (lk_idx[m] == PORT_W'(j))) begin
          links_d[m][j] = '0;
        end
        if (lk_en[m] && (lk_idx[m] == PORT_W'(j))) begin
          links_d[m][j] = lk_out[m];
        end
      end
    end
  end

  always_comb begin
    flags_d = flags_q;
    if (cmd_i.exec && slot_ok) begin
      case (op)
        OP_STORE: flags_d[slot_idx] = pvalid_q;
        OP_CLEAR: flags_d[slot_idx] = 1'b0;
        default:  ;
      endcase
    end
  end

  always_comb begin
    acc_d  = 1'b0;
    conn_d = '0;
    src_d  = SRC_NONE;
    case (op)
      OP_CONNECT:    acc_d = inp_ok && outp_ok;
      OP_DISCONNECT: acc_d = inp_ok;
      OP_READ: begin
        if (inp_ok) begin
          acc_d  = 1'b1;
          conn_d = links_q[dir_q][inp_idx];
        end
      end
      OP_FIND: begin
        if (outp_ok) begin
          acc_d = 1'b1;
          if (hold_en[dir_q]) begin
            src_d = signed'(SrcW'(hold_idx[dir_q]));
          end
        end
      end
      OP_STORE:      acc_d = slot_ok;
      OP_CLEAR:      acc_d = slot_ok;
      OP_RESTORE:    acc_d = flag_sel;
      default:       acc_d = 1'b0;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.exec) begin
      cnt_d = '0;
    end else if (cmd_i.step) begin
      cnt_d = cnt_q + PORT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < 2; m++) begin
        for (int j = 0; j < PORTS; j++) begin
          links_q[m][j] <= '0;
        end
      end
      flags_q <= '0;
      cnt_q   <= '0;
    end else begin
      links_q <= links_d;
      flags_q <= flags_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= operation_i;
      dir_q    <= direction_i;
      inp_q    <= input_port_i;
      outp_q   <= output_port_i;
      slot_q   <= preset_slot_i;
      emap_q   <= preset_emission_map_i;
      rmap_q   <= preset_reception_map_i;
      pvalid_q <= preset_valid_i;
    end
    if (cmd_i.exec) begin
      acc_q  <= acc_d;
      conn_q <= conn_d;
      src_q  <= src_d;
    end
  end

  assign status_o.restore_go = (op == OP_RESTORE) && flag_sel;
  assign status_o.step_last  = (cnt_q == PORT_W'(PORTS - 1));

  assign accepted_o         = acc_q;
  assign connected_output_o = conn_q;
  assign source_index_o     = src_q;

`ifndef SYNTHESIS
  a_step_needs_set_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (op == OP_RESTORE) && flag_sel)
    else $error("Restore step runs without a set preset slot.");

  a_connect_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && (op == OP_CONNECT) && inp_ok && outp_ok
    |=> links_q[$past(dir_q)][$past(inp_idx)] == $past(outp_q))
    else $error("Connect did not store the output at its input.");

  a_step_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step && lk_en[0] |=> links_q[0][$past(cnt_q)] == $past(lk_out[0]))
    else $error("Restore step did not store the emission entry.");
`endif

endmodule

[hdl/ccx_ctrl.sv]
// ----------------------------------------------------------------------------
// Crosspoint connection table controller
// Sequences intake, execution, restore steps and the result register.
// ----------------------------------------------------------------------------
module ccx_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ccx_pkg::ccx_cmd_t    cmd_o,
  input  ccx_pkg::ccx_status_t status_i
);

  import ccx_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_STEP
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec = (state_q == S_EXEC) && out_free;
    cmd_o.step = (state_q == S_STEP);
    state_d    = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = status_i.restore_go ? S_STEP : S_IDLE;
        end
      end
      S_STEP: begin
        if (status_i.step_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_load_then_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_EXEC)
    else $error("Accepted transfer was not followed by execution.");

  a_last_step_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) && status_i.step_last |=> state_q == S_IDLE)
    else $error("Restore did not end after the last step.");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> !(out_valid_q && out_stall_i))
    else $error("Result register overwritten while its transfer is pending.");
`endif

endmodule

[hdl/crosspoint_connection_table.sv]
// ----------------------------------------------------------------------------
// Crosspoint connection table
// Emission and reception link maps with connect, disconnect, lookups and
// preset store, clear and restore.
// ----------------------------------------------------------------------------
//  Channel  Handshake                 Payload
//  in       in_valid_i / in_stall_o   operation_i .. preset_valid_i
//  out      out_valid_o / out_stall_i accepted_o, connected_output_o,
//                                     source_index_o
//
// An item is first taken as a transfer and then executed.
// A restore of a set slot adds one step per input, in each of which one
// link update of each map runs; the preset read comes from a registered RAM.
// Reset clears both maps and all preset valid flags at once.
// The input stalls while an item is in work. The result waits in an output
// register, so execution stalls only while a previous result is unclaimed.
module crosspoint_connection_table #(
  parameter int PORTS        = 8,
  parameter int PRESET_SLOTS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      operation_i,
  input  logic                            direction_i,
  input  logic [ccx_pkg::PortNumW-1:0]    input_port_i,
  input  logic [ccx_pkg::PortNumW-1:0]    output_port_i,
  input  logic [ccx_pkg::PortNumW-1:0]    preset_slot_i,
  input  logic [ccx_pkg::MapW-1:0]        preset_emission_map_i,
  input  logic [ccx_pkg::MapW-1:0]        preset_reception_map_i,
  input  logic                            preset_valid_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            accepted_o,
  output logic [ccx_pkg::PortNumW-1:0]    connected_output_o,
  output logic signed [ccx_pkg::SrcW-1:0] source_index_o
);

  import ccx_pkg::*;

  ccx_cmd_t    cmd;
  ccx_status_t status;

  ccx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  ccx_dp #(
    .PORTS       (PORTS),
    .PRESET_SLOTS(PRESET_SLOTS)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .status_o              (status),
    .operation_i           (operation_i),
    .direction_i           (direction_i),
    .input_port_i          (input_port_i),
    .output_port_i         (output_port_i),
    .preset_slot_i         (preset_slot_i),
    .preset_emission_map_i (preset_emission_map_i),
    .preset_reception_map_i(preset_reception_map_i),
    .preset_valid_i        (preset_valid_i),
    .accepted_o            (accepted_o),
    .connected_output_o    (connected_output_o),
    .source_index_o        (source_index_o)
  );

endmodule

[bench/crosspoint_connection_table_test.sv]
// ----------------------------------------------------------------------------
// Crosspoint connection table testbench
// Sends connect, disconnect, lookup and preset commands, first a directed set
// and then random traffic, with random gaps and stalls on both channels. Each
// command is run through a local copy of both link maps and the preset slots
// when its transfer is taken, and every reply is checked against that.
// ----------------------------------------------------------------------------
module crosspoint_connection_table_test;
  import ccx_pkg::*;

  localparam int PORTS        = 8;
  localparam int PRESET_SLOTS = 8;
  localparam int RandomItems  = 2000;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam logic       EMISSION  = 1'b0;
  localparam logic       RECEPTION = 1'b1;

  typedef struct {
    logic [2:0]          op;
    logic                dir;
    logic [PortNumW-1:0] in_port;
    logic [PortNumW-1:0] out_port;
    logic [PortNumW-1:0] slot;
    logic [MapW-1:0]     emap;
    logic [MapW-1:0]     rmap;
    logic                pvalid;
  } command_t;

  typedef struct {
    logic                   accepted;
    logic [PortNumW-1:0]    connected;
    logic signed [SrcW-1:0] source;
  } reply_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [2:0]             operation_i;
  logic                   direction_i;
  logic [PortNumW-1:0]    input_port_i;
  logic [PortNumW-1:0]    output_port_i;
  logic [PortNumW-1:0]    preset_slot_i;
  logic [MapW-1:0]        preset_emission_map_i;
  logic [MapW-1:0]        preset_reception_map_i;
  logic                   preset_valid_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic                   accepted_o;
  logic [PortNumW-1:0]    connected_output_o;
  logic signed [SrcW-1:0] source_index_o;

  logic [PortNumW-1:0] links [2][PORTS];
  logic [MapW-1:0]     preset_emission [PRESET_SLOTS];
  logic [MapW-1:0]     preset_reception [PRESET_SLOTS];
  logic                preset_set [PRESET_SLOTS];

  reply_t expected_replies [$];
  int     failures;
  bit     quiet_gaps;

  crosspoint_connection_table #(
    .PORTS       (PORTS),
    .PRESET_SLOTS(PRESET_SLOTS)
  ) u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .operation_i           (operation_i),
    .direction_i           (direction_i),
    .input_port_i          (input_port_i),
    .output_port_i         (output_port_i),
    .preset_slot_i         (preset_slot_i),
    .preset_emission_map_i (preset_emission_map_i),
    .preset_reception_map_i(preset_reception_map_i),
    .preset_valid_i        (preset_valid_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .accepted_o            (accepted_o),
    .connected_output_o    (connected_output_o),
    .source_index_o        (source_index_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic bit port_ok(input logic [PortNumW-1:0] p);
    return p >= 1 && p <= PORTS;
  endfunction

  function automatic bit slot_ok(input logic [PortNumW-1:0] s);
    return s >= 1 && s <= PRESET_SLOTS;
  endfunction

  function automatic logic signed [SrcW-1:0] lowest_holder(input logic dir,
                                                           input logic [PortNumW-1:0] outp);
    if (!port_ok(outp)) return SRC_NONE;
    for (int i = 0; i < PORTS; i++) begin
      if (links[dir][i] == outp) return SrcW'(i);
    end
    return SRC_NONE;
  endfunction

  function automatic bit make_link(input logic dir, input logic [PortNumW-1:0] inp,
                                   input logic [PortNumW-1:0] outp);
    logic signed [SrcW-1:0] holder;
    if (!port_ok(inp) || !port_ok(outp)) return 1'b0;
    holder = lowest_holder(dir, outp);
    if (holder != SRC_NONE) links[dir][int'(holder)] = '0;
    links[dir][inp - 1] = outp;
    return 1'b1;
  endfunction

  function automatic logic [PortNumW-1:0] preset_entry(input logic [MapW-1:0] m, input int i);
    return (i < MapW / 4) ? m[4*i +: 4] : '0;
  endfunction

  function automatic reply_t compute_reply(input command_t c);
    reply_t r;
    r.accepted  = 1'b0;
    r.connected = '0;
    r.source    = SRC_NONE;
    case (c.op)
      OP_CONNECT: r.accepted = make_link(c.dir, c.in_port, c.out_port);
      OP_DISCONNECT: begin
        if (port_ok(c.in_port)) begin
          links[c.dir][c.in_port - 1] = '0;
          r.accepted = 1'b1;
        end
      end
      OP_READ: begin
        if (port_ok(c.in_port)) begin
          r.connected = links[c.dir][c.in_port - 1];
          r.accepted  = 1'b1;
        end
      end
      OP_FIND: begin
        if (port_ok(c.out_port)) begin
          r.source   = lowest_holder(c.dir, c.out_port);
          r.accepted = 1'b1;
        end
      end
      OP_STORE: begin
        if (slot_ok(c.slot)) begin
          preset_emission[c.slot - 1]  = c.emap;
          preset_reception[c.slot - 1] = c.rmap;
          preset_set[c.slot - 1]       = c.pvalid;
          r.accepted = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (slot_ok(c.slot)) begin
          preset_emission[c.slot - 1]  = '0;
          preset_reception[c.slot - 1] = '0;
          preset_set[c.slot - 1]       = 1'b0;
          r.accepted = 1'b1;
        end
      end
      OP_RESTORE: begin
        if (slot_ok(c.slot) && preset_set[c.slot - 1]) begin
          for (int i = 0; i < PORTS; i++) begin
            void'(make_link(EMISSION, PortNumW'(i + 1),
                            preset_entry(preset_emission[c.slot - 1], i)));
            void'(make_link(RECEPTION, PortNumW'(i + 1),
                            preset_entry(preset_reception[c.slot - 1], i)));
          end
          r.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic command_t make_command(input logic [2:0] op, input logic dir,
                                            input logic [PortNumW-1:0] inp,
                                            input logic [PortNumW-1:0] outp,
                                            input logic [PortNumW-1:0] slot,
                                            input logic [MapW-1:0] emap,
                                            input logic [MapW-1:0] rmap,
                                            input logic pvalid);
    command_t c;
    c.op       = op;
    c.dir      = dir;
    c.in_port  = inp;
    c.out_port = outp;
    c.slot     = slot;
    c.emap     = emap;
    c.rmap     = rmap;
    c.pvalid   = pvalid;
    return c;
  endfunction

  task automatic send_command(input command_t c);
    int gap;
    gap = quiet_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i             <= 1'b1;
    operation_i            <= c.op;
    direction_i            <= c.dir;
    input_port_i           <= c.in_port;
    output_port_i          <= c.out_port;
    preset_slot_i          <= c.slot;
    preset_emission_map_i  <= c.emap;
    preset_reception_map_i <= c.rmap;
    preset_valid_i         <= c.pvalid;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    expected_replies.push_back(compute_reply(c));
  endtask

  task automatic wait_until_drained();
    while (expected_replies.size() != 0) @(posedge clk_i);
  endtask

  initial begin : reply_checker
    reply_t want;
    int     hold;
    out_stall_i <= 1'b1;
    @(posedge rst_ni);
    forever begin
      hold = quiet_gaps ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
      if (expected_replies.size() == 0) begin
        $error("Unexpected reply: accepted %0b, connected_output %0d, source_index %0d",
               accepted_o, connected_output_o, source_index_o);
        failures++;
      end else begin
        want = expected_replies.pop_front();
        if (accepted_o !== want.accepted) begin
          $error("accepted: expected %0b, got %0b", want.accepted, accepted_o);
          failures++;
        end
        if (connected_output_o !== want.connected) begin
          $error("connected_output: expected %0d, got %0d", want.connected,
                 connected_output_o);
          failures++;
        end
        if (source_index_o !== want.source) begin
          $error("source_index: expected %0d, got %0d", want.source, source_index_o);
          failures++;
        end
      end
    end
  end

  task automatic test_link_control();
    send_command(make_command(OP_CONNECT, EMISSION, 4'd1, 4'd8, 4'd0, '0, '0, 1'b0));
    send_command(make_command(OP_CONNECT, EMISSION, 4'd8, 4'd8, 4'd0, '0, '0, 1'b0));
    send_command(make_command(OP_READ, EMISSION, 4'd1, 4'd0, 4'd0, '0, '0, 1'b0));
    send_command(make_command(OP_FIND, EMISSION, 4'd0, 4'd8, 4'd0, '0, '0, 1'b0));
    send_command(make_command(OP_CONNECT, RECEPTION, 4'd0, 4'd3, 4'd0, '0, '0, 1'b0));
    send_command(make_command(OP_CONNECT, RECEPTION, 4'd9, 4'd3, 4'd0, '0, '0, 1'b0));
    send_command(make_command(OP_CONNECT, RECEPTION, 4'd3, 4'd0, 4'd0, '0, '0, 1'b0));
    send_command(make_command(OP_CONNECT, RECEPTION, 4'd15, 4'd15, 4'd15, '1, '1, 1'b1));
    send_command(make_command(OP_DISCONNECT, EMISSION, 4'd8, 4'd15, 4'd0, '0, '0, 1'b0));
    send_command(make_command(OP_DISCONNECT, EMISSION, 4'd0, 4'd1, 4'd0, '0, '0, 1'b0));
    send_command(make_command(OP_DISCONNECT, RECEPTION, 4'd15, 4'd1, 4'd0, '0, '0, 1'b0));
  endtask

  task automatic test_lookups();
    send_command(make_command(OP_READ, RECEPTION, 4'd8, 4'd0, 4'd0, '0, '0, 1'b0));
    send_command(make_command(OP_READ, EMISSION, 4'd0, 4'd0, 4'd0, '0, '0, 1'b0));
    send_command(make_command(OP_READ, EMISSION, 4'd15, 4'd15, 4'd0, '0, '0, 1'b0));
    send_command(make_command(OP_FIND, EMISSION, 4'd1, 4'd0, 4'd0, '0, '0, 1'b0));
    send_command(make_command(OP_FIND, RECEPTION, 4'd1, 4'd9, 4'd0, '0, '0, 1'b0));
    send_command(make_command(OP_FIND, RECEPTION, 4'd0, 4'd1, 4'd0, '0, '0, 1'b0));
  endtask

  task automatic test_presets();
    send_command(make_command(OP_STORE, EMISSION, 4'd0, 4'd0, 4'd0, '1, '1, 1'b1));
    send_command(make_command(OP_STORE, EMISSION, 4'd0, 4'd0, 4'd9, '1, '1, 1'b1));
    send_command(make_command(OP_STORE, RECEPTION, 4'd0, 4'd0, 4'd1,
                              32'h5390_F213, 32'h1234_5678, 1'b1));
    send_command(make_command(OP_STORE, EMISSION, 4'd0, 4'd0, 4'd8, '1, '1, 1'b0));
    send_command(make_command(OP_RESTORE, EMISSION, 4'd0, 4'd0, 4'd8, '0, '0, 1'b0));
    send_command(make_command(OP_RESTORE, EMISSION, 4'd0, 4'd0, 4'd1, '0, '0, 1'b0));
    send_command(make_command(OP_RESTORE, EMISSION, 4'd0, 4'd0, 4'd0, '0, '0, 1'b0));
    send_command(make_command(OP_FIND, EMISSION, 4'd0, 4'd3, 4'd0, '0, '0, 1'b0));
    send_command(make_command(OP_CLEAR, EMISSION, 4'd0, 4'd0, 4'd1, '0, '0, 1'b0));
    send_command(make_command(OP_RESTORE, RECEPTION, 4'd0, 4'd0, 4'd1, '0, '0, 1'b0));
    send_command(make_command(OP_CLEAR, EMISSION, 4'd0, 4'd0, 4'd15, '0, '0, 1'b0));
  endtask

  task automatic test_unused_code();
    send_command(make_command(OP_UNUSED, RECEPTION, 4'd1, 4'd2, 4'd1, '0, '0, 1'b1));
  endtask

  function automatic logic [PortNumW-1:0] random_port();
    if ($urandom_range(0, 9) == 0) return PortNumW'($urandom_range(0, 15));
    return PortNumW'($urandom_range(1, PORTS));
  endfunction

  function automatic logic [MapW-1:0] random_map();
    logic [MapW-1:0] m;
    if ($urandom_range(0, 7) == 0) return MapW'($urandom());
    for (int i = 0; i < MapW / 4; i++) begin
      m[4*i +: 4] = ($urandom_range(0, 5) == 0) ? '0 : random_port();
    end
    return m;
  endfunction

  task automatic test_random_traffic();
    command_t c;
    int       pick;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 100 == 0) quiet_gaps = ($urandom_range(0, 3) == 0);
      if (n % 500 == 499) begin
        in_valid_i <= 1'b0;
        wait_until_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 22) c.op = OP_CONNECT;
      else if (pick < 32) c.op = OP_DISCONNECT;
      else if (pick < 50) c.op = OP_READ;
      else if (pick < 68) c.op = OP_FIND;
      else if (pick < 78) c.op = OP_STORE;
      else if (pick < 84) c.op = OP_CLEAR;
      else if (pick < 97) c.op = OP_RESTORE;
      else c.op = OP_UNUSED;
      c.dir      = 1'($urandom_range(0, 1));
      c.in_port  = random_port();
      c.out_port = random_port();
      c.slot     = random_port();
      c.emap     = random_map();
      c.rmap     = random_map();
      c.pvalid   = ($urandom_range(0, 4) != 0);
      send_command(c);
    end
    quiet_gaps = 1'b0;
  endtask

  initial begin : test_sequence
    failures   = 0;
    quiet_gaps = 1'b0;
    for (int i = 0; i < PORTS; i++) begin
      links[EMISSION][i]  = '0;
      links[RECEPTION][i] = '0;
    end
    for (int s = 0; s < PRESET_SLOTS; s++) begin
      preset_emission[s]  = '0;
      preset_reception[s] = '0;
      preset_set[s]       = 1'b0;
    end
    rst_ni                 <= 1'b0;
    in_valid_i             <= 1'b0;
    operation_i            <= OP_CONNECT;
    direction_i            <= EMISSION;
    input_port_i           <= '0;
    output_port_i          <= '0;
    preset_slot_i          <= '0;
    preset_emission_map_i  <= '0;
    preset_reception_map_i <= '0;
    preset_valid_i         <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_link_control();
    test_lookups();
    test_presets();
    test_unused_code();
    test_random_traffic();

    in_valid_i <= 1'b0;
    wait_until_drained();
    repeat (2 * PORTS + 8) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/ccx_pkg.sv
hdl/ccx_ram.sv
hdl/ccx_dp.sv
hdl/ccx_ctrl.sv
hdl/crosspoint_connection_table.sv
bench/crosspoint_connection_table_test.sv
